/* hdl/inmx_pkg.sv */
// Package for the impulse noise table mixer: shared constants, codes and types.
// Used by inmx_chan and impulse_noise_table_mixer_unit; depends on nothing else.
package inmx_pkg;

  // Default configuration of the block.
  localparam int unsigned ChannelsDef   = 4;
  localparam int unsigned TableDepthDef = 4096;
  localparam int unsigned SampleBitsDef = 16;

  // Fixed widths of the item fields and the configuration port.
  localparam int unsigned ChanW       = 2;
  localparam int unsigned EntryW      = 12;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned NumLenRegs  = 4;

  // Operation carried by an input item.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  // Per-channel control from the top level to a channel table.
  typedef struct packed {
    logic rd_en;   // read the entry at the current position
    logic tick;    // a tick item was accepted: advance the position
    logic wr_en;   // a load item writes this channel's table
  } chan_ctrl_t;

endpackage

/* hdl/inmx_chan.sv */
// One channel of the mixer: sample table memory, read position and length register.
// Depends on inmx_pkg for the control struct.
module inmx_chan import inmx_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  localparam int unsigned PosW  = $clog2(TABLE_DEPTH),
  localparam int unsigned LenW  = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned WordW = 2 * SAMPLE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chan_ctrl_t       ctrl_i,
  input  logic             len_we_i,
  input  logic [LenW-1:0]  len_i,
  input  logic [PosW-1:0]  wr_addr_i,
  input  logic [WordW-1:0] wr_data_i,
  output logic [WordW-1:0] rd_data_o,
  output logic             rd_act_o
);

  localparam int unsigned NxtW = PosW + 1;

  logic [WordW-1:0] tab_mem_q [TABLE_DEPTH];
  logic [WordW-1:0] rd_data_q;
  logic             rd_act_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [LenW-1:0]  len_q;
  logic             active;
  logic [NxtW-1:0]  pos_nxt;

  assign active = (len_q != '0);

  // Table memory: one write port for loads, one registered read port for ticks.
  // A read and a write in the same cycle return the old entry, which matches
  // the order of the items.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      tab_mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= tab_mem_q[pos_q];
    end
  end

  // Next position wraps to zero at or beyond the length.
  always_comb begin
    pos_nxt = NxtW'(pos_q) + NxtW'(1);
    pos_d   = pos_q;
    if (ctrl_i.tick && active) begin
      if (pos_nxt >= NxtW'(len_q)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_nxt[PosW-1:0];
      end
    end
  end

  // Position, length and the flag telling whether the read sample counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      rd_act_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (len_we_i) begin
        len_q <= len_i;
      end
      if (ctrl_i.rd_en) begin
        rd_act_q <= ctrl_i.tick && active;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_act_o  = rd_act_q;

endmodule

/* hdl/impulse_noise_table_mixer_unit.sv */
// Top level of the impulse noise table mixer: handshakes, adder and saturation.
// Depends on inmx_pkg and instantiates one inmx_chan per channel.
//
// Usage:
// Items arrive on the in channel (valid/ready). A load item writes one complex
// sample into a channel's table and produces no result. A tick item reads the
// sample at each enabled channel's position, sums them, saturates the sums to
// SAMPLE_BITS and sets clipped if either sum saturated; every enabled position
// then advances by one and wraps at the channel's length.
// Lengths are written on the plain configuration port (index i is channel i);
// a length of zero disables the channel, a length above TABLE_DEPTH acts as it.
// Pipeline: three register stages (table read, adder, saturation register); a
// tick accepted at the input passes through them in that order, and its result
// is offered to the receiver once it sits in the saturation register.
// Throughput: one item per cycle unless the output stalls; the single write port
// and registered read port of each table take one access of each kind every cycle.
// Reset clears positions, lengths and all valid flags; table contents are not
// cleared and must be loaded before ticks read them, so no clearing pass runs.
// When the receiver stalls, the three stages fill up one by one; input ready
// drops only once every stage holds a result.
module impulse_noise_table_mixer_unit import inmx_pkg::*; #(
  parameter int unsigned CHANNELS    = ChannelsDef,
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_idx_i,
  input  logic [CfgDataW-1:0]           cfg_data_i,
  // Input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [ChanW-1:0]              channel_i,
  input  logic [EntryW-1:0]             entry_index_i,
  input  logic signed [SAMPLE_BITS-1:0] load_real_i,
  input  logic signed [SAMPLE_BITS-1:0] load_imag_i,
  // Result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sum_real_o,
  output logic signed [SAMPLE_BITS-1:0] sum_imag_o,
  output logic                          clipped_o
);

  localparam int unsigned PosW  = $clog2(TABLE_DEPTH);
  localparam int unsigned LenW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WordW = 2 * SAMPLE_BITS;
  localparam int unsigned SumW  = SAMPLE_BITS + $clog2(CHANNELS) + 1;
  localparam logic signed [SumW-1:0] SatHi = SumW'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SumW-1:0] SatLo = -SatHi - SumW'(1);

  logic                   accept, tick_acc, load_acc, load_ok;
  logic                   ld1, ld2, ld3;
  logic                   s1_valid_q, s2_valid_q, out_valid_q;
  logic [LenW-1:0]        cfg_len;
  logic [31:0]            cfg_ext;
  logic [PosW-1:0]        wr_addr;
  logic [WordW-1:0]       wr_data;
  logic [WordW-1:0]       rd_data [CHANNELS];
  logic [CHANNELS-1:0]    rd_act;
  logic signed [SumW-1:0] sum_re_d, sum_im_d, sum_re_q, sum_im_q;
  logic signed [SAMPLE_BITS-1:0] sat_re, sat_im;
  logic                   sat_clip;
  logic signed [SAMPLE_BITS-1:0] out_re_q, out_im_q;
  logic                   out_clip_q;

  // Stage enables: a stage loads when it is empty or its successor takes its item.
  assign ld3        = !out_valid_q || out_ready_i;
  assign ld2        = !s2_valid_q || ld3;
  assign ld1        = !s1_valid_q || ld2;
  assign in_ready_o = ld1;
  assign accept     = in_valid_i && ld1;
  assign tick_acc   = accept && (op_e'(op_i) == OP_TICK);
  assign load_acc   = accept && (op_e'(op_i) == OP_LOAD);

  // Loads beyond the table depth are dropped.
  assign load_ok = load_acc && (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign wr_addr = PosW'(32'(entry_index_i));
  assign wr_data = {load_imag_i, load_real_i};

  // Length written by configuration, clamped to the table depth.
  always_comb begin
    cfg_ext = 32'(cfg_data_i);
    if (cfg_ext > 32'(TABLE_DEPTH)) begin
      cfg_len = LenW'(TABLE_DEPTH);
    end else begin
      cfg_len = LenW'(cfg_ext);
    end
  end

  // Channel tables.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    chan_ctrl_t ctrl;
    logic       len_we;

    assign ctrl.rd_en = ld1;
    assign ctrl.tick  = tick_acc;
    assign ctrl.wr_en = load_ok && (32'(channel_i) == 32'(c));
    assign len_we     = cfg_we_i && (c < NumLenRegs) && (32'(cfg_idx_i) == 32'(c));

    inmx_chan #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chan (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .len_we_i  (len_we),
      .len_i     (cfg_len),
      .wr_addr_i (wr_addr),
      .wr_data_i (wr_data),
      .rd_data_o (rd_data[c]),
      .rd_act_o  (rd_act[c])
    );
  end

  // Sum of the samples of the enabled channels.
  always_comb begin
    sum_re_d = '0;
    sum_im_d = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (rd_act[c]) begin
        sum_re_d = sum_re_d + SumW'($signed(rd_data[c][SAMPLE_BITS-1:0]));
        sum_im_d = sum_im_d + SumW'($signed(rd_data[c][WordW-1:SAMPLE_BITS]));
      end
    end
  end

  // Saturation to the sample width.
  always_comb begin
    sat_clip = 1'b0;
    if (sum_re_q > SatHi) begin
      sat_re   = SAMPLE_BITS'(SatHi);
      sat_clip = 1'b1;
    end else if (sum_re_q < SatLo) begin
      sat_re   = SAMPLE_BITS'(SatLo);
      sat_clip = 1'b1;
    end else begin
      sat_re = sum_re_q[SAMPLE_BITS-1:0];
    end
    if (sum_im_q > SatHi) begin
      sat_im   = SAMPLE_BITS'(SatHi);
      sat_clip = 1'b1;
    end else if (sum_im_q < SatLo) begin
      sat_im   = SAMPLE_BITS'(SatLo);
      sat_clip = 1'b1;
    end else begin
      sat_im = sum_im_q[SAMPLE_BITS-1:0];
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld1) begin
        s1_valid_q <= tick_acc;
      end
      if (ld2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (ld3) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Payload registers of the adder and output stages.
  always_ff @(posedge clk_i) begin
    if (ld2) begin
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
    end
    if (ld3) begin
      out_re_q   <= sat_re;
      out_im_q   <= sat_im;
      out_clip_q <= sat_clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_real_o  = out_re_q;
  assign sum_imag_o  = out_im_q;
  assign clipped_o   = out_clip_q;

endmodule
